/* rtl/dlpc_pkg.sv */
// Shared types and constants of the disk lattice point counter.
package dlpc_pkg;

	// Coordinate format: INT_BITS integer bits and FRAC_BITS fractional bits in 32 bits.
	localparam int COORD_W   = 32;
	localparam int INT_BITS  = 16;
	localparam int FRAC_BITS = COORD_W - INT_BITS;

	// Internal signed width for coordinates, offsets and column spans.
	localparam int WIDE_W = 34;

	// Radius width, square root width and radicand width.
	localparam int RAD_W   = 31;
	localparam int ROOT_W  = RAD_W;
	localparam int RADIC_W = 2 * ROOT_W;

	// Result count width.
	localparam int CNT_W = 33;

	// One unit in raw fixed point, and the mask of the fractional bits.
	localparam logic [WIDE_W-1:0] ONE_RAW   = WIDE_W'(1) << FRAC_BITS;
	localparam logic [WIDE_W-1:0] FRAC_MASK = ONE_RAW - WIDE_W'(1);

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQR,
		ST_INIT,
		ST_CHECK,
		ST_MUL,
		ST_ROOT,
		ST_WAIT,
		ST_SPAN,
		ST_ACC,
		ST_FINISH
	} state_t;

	// Controls from the sequencer to the datapath.
	typedef struct packed {
		logic load;
		logic mul_r;
		logic mul_dx;
		logic init;
		logic sqrt_start;
		logic span;
		logic acc;
		logic finish;
	} ctl_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic col_done;
		logic sqrt_done;
		logic out_free;
	} sts_t;

endpackage

/* rtl/dlpc_isqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
module dlpc_isqrt
	import dlpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RADIC_W-1:0] operand,
	output logic               done,
	output logic [ROOT_W-1:0]  root
);

	localparam int STEP_W = $clog2(ROOT_W);
	localparam int REM_W  = ROOT_W + 3;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_W - 1);

	logic [RADIC_W-1:0] opnd_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;

	logic [REM_W-1:0] rem_shift;
	logic [REM_W-1:0] trial;
	logic             fits;

	// One restoring step: bring down two bits and try the next root bit.
	always_comb begin
		rem_shift = {rem_q[REM_W-3:0], opnd_q[RADIC_W-1:RADIC_W-2]};
		trial     = {1'b0, root_q, 2'b01};
		fits      = (rem_shift >= trial);
	end

	// Step counter and handshake flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Radicand, remainder and partial root.
	always_ff @(posedge clk) begin
		if (start) begin
			opnd_q <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			opnd_q <= {opnd_q[RADIC_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_shift - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* rtl/dlpc_seq.sv */
// Sequencer that steps the shared multiplier and square root over the columns.
module dlpc_seq
	import dlpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  sts_t sts,
	output logic busy,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SQR;
			ST_SQR:    state_d = ST_INIT;
			ST_INIT:   state_d = ST_CHECK;
			ST_CHECK:  state_d = sts.col_done ? ST_FINISH : ST_MUL;
			ST_MUL:    state_d = ST_ROOT;
			ST_ROOT:   state_d = ST_WAIT;
			ST_WAIT:   if (sts.sqrt_done) state_d = ST_SPAN;
			ST_SPAN:   state_d = ST_ACC;
			ST_ACC:    state_d = ST_CHECK;
			ST_FINISH: if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath controls decoded from the state.
	always_comb begin
		ctl        = '0;
		busy       = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:   ctl.load       = in_valid;
			ST_SQR:    ctl.mul_r      = 1'b1;
			ST_INIT:   ctl.init       = 1'b1;
			ST_MUL:    ctl.mul_dx     = 1'b1;
			ST_ROOT:   ctl.sqrt_start = 1'b1;
			ST_SPAN:   ctl.span       = 1'b1;
			ST_ACC:    ctl.acc        = 1'b1;
			ST_FINISH: ctl.finish     = sts.out_free;
			default:   ctl            = '0;
		endcase
	end

endmodule

/* rtl/disk_lattice_point_counter_unit.sv */
// Top level of the disk lattice point counter: datapath, shared multiplier and control.
//
// Each input word gives a disk by a signed center and an unsigned radius in fixed point
// with FRAC_BITS fractional bits; one output word returns the number of integer lattice
// points inside or on the circle, modulo 2^33. The block walks the integer columns that
// the disk covers, one at a time. For each column the 31-step integer square root runs
// two radicand bits per cycle, with the multiply and span steps around it. The number of
// covered columns is about 2 * radius / 2^FRAC_BITS + 1. The input is stalled from
// acceptance until the result is placed in the output register; a waiting result does not
// block the next input word.
module disk_lattice_point_counter_unit
	import dlpc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] center_x,
	input  logic signed [COORD_W-1:0] center_y,
	input  logic        [RAD_W-1:0]   radius,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic        [CNT_W-1:0]   point_count
);

	ctl_t ctl;
	sts_t sts;
	logic busy;

	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic        [RAD_W-1:0]   r_q;
	logic        [RADIC_W-1:0] prod_q;
	logic        [RADIC_W-1:0] r2_q;
	logic signed [WIDE_W-1:0]  dx_q;
	logic signed [WIDE_W-1:0]  up_q;
	logic signed [WIDE_W-1:0]  down_q;
	logic        [CNT_W-1:0]   total_q;
	logic        [CNT_W-1:0]   count_q;
	logic                      out_valid_q;

	logic signed [WIDE_W-1:0]  cx_w;
	logic signed [WIDE_W-1:0]  cy_w;
	logic signed [WIDE_W-1:0]  r_w;
	logic signed [WIDE_W-1:0]  first_w;
	logic signed [WIDE_W-1:0]  dx_first;
	logic signed [WIDE_W-1:0]  adx;
	logic        [RAD_W-1:0]   mul_a;
	logic        [RADIC_W-1:0] prod_c;
	logic        [ROOT_W-1:0]  root;
	logic                      root_done;
	logic signed [WIDE_W-1:0]  s_w;
	logic signed [WIDE_W-1:0]  up_raw;
	logic signed [WIDE_W-1:0]  down_raw;
	logic signed [WIDE_W-1:0]  span_w;

	// Widened operands.
	always_comb begin
		cx_w = WIDE_W'(cx_q);
		cy_w = WIDE_W'(cy_q);
		r_w  = $signed({{(WIDE_W - RAD_W){1'b0}}, r_q});
		s_w  = $signed({{(WIDE_W - ROOT_W){1'b0}}, root});
	end

	// First column offset: the ceiling of cx - r in whole units, minus cx.
	always_comb begin
		first_w  = (cx_w - r_w + $signed(FRAC_MASK)) & $signed(~FRAC_MASK);
		dx_first = first_w - cx_w;
	end

	// Shared multiplier: squares the radius once, then each column offset.
	always_comb begin
		adx    = dx_q[WIDE_W-1] ? -dx_q : dx_q;
		mul_a  = ctl.mul_r ? r_q : adx[RAD_W-1:0];
		prod_c = RADIC_W'(mul_a) * RADIC_W'(mul_a);
	end

	// Top and bottom rows inside the disk for the current column.
	always_comb begin
		up_raw   = (cy_w + s_w) >>> FRAC_BITS;
		down_raw = (cy_w - s_w + $signed(FRAC_MASK)) >>> FRAC_BITS;
		span_w   = up_q - down_q;
	end

	// Column walk is over once the offset passes the radius.
	always_comb begin
		sts.col_done  = (dx_q > r_w);
		sts.sqrt_done = root_done;
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cx_q <= center_x;
			cy_q <= center_y;
			r_q  <= radius;
		end
		if (ctl.mul_r || ctl.mul_dx) begin
			prod_q <= prod_c;
		end
		if (ctl.init) begin
			r2_q    <= prod_q;
			dx_q    <= dx_first;
			total_q <= '0;
		end
		if (ctl.span) begin
			up_q   <= up_raw;
			down_q <= down_raw;
		end
		if (ctl.acc) begin
			dx_q <= dx_q + $signed(ONE_RAW);
			if (!span_w[WIDE_W-1]) begin
				total_q <= total_q + span_w[CNT_W-1:0] + CNT_W'(1);
			end
		end
		if (ctl.finish) begin
			count_q <= total_q;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	dlpc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.busy     (busy),
		.ctl      (ctl)
	);

	dlpc_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.sqrt_start),
		.operand (r2_q - prod_q),
		.done    (root_done),
		.root    (root)
	);

	assign in_stall    = busy;
	assign out_valid   = out_valid_q;
	assign point_count = count_q;

endmodule

/* rtl/dlpc_checker.sv */
// Port-level checks of the disk lattice point counter, bound to the top level.
module dlpc_checker
	import dlpc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [CNT_W-1:0] point_count
);

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_count))
		else $error("stalled result word changed");

	// The block is busy right after it takes a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after acceptance");

	// A fresh result appears only once the block is ready again.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result shown while still busy");

	// No result can follow an accepted word in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind disk_lattice_point_counter_unit dlpc_checker u_dlpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.point_count (point_count)
);
